FILE: design/drm_pkg.sv
package drm_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_POINT = 2'd1,
    OP_RANGE = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_PREAD,
    ST_RSCAN
  } state_t;

  typedef struct packed {
    logic en;
    logic first;
  } mm_ctl_t;

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned FIELD_W = 16;

endpackage

FILE: design/drm_store.sv
module drm_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned DW    = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/drm_minmax.sv
module drm_minmax #(
  parameter int unsigned DW = 16
) (
  input  logic                        clk,
  input  drm_pkg::mm_ctl_t            ctl,
  input  logic signed [DW-1:0]        data,
  output logic signed [DW-1:0]        lo_nxt,
  output logic signed [DW-1:0]        hi_nxt
);
  import drm_pkg::*;

  logic signed [DW-1:0] lo_r;
  logic signed [DW-1:0] hi_r;

  always_comb begin
    if (ctl.first) begin
      lo_nxt = data;
      hi_nxt = data;
    end else begin
      lo_nxt = (data < lo_r) ? data : lo_r;
      hi_nxt = (data > hi_r) ? data : hi_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

endmodule

FILE: design/delta_rle_decode_range_minmax.sv
// Delta / zero-run decoder into a STORE_DEPTH-entry sample memory, with point and
// range min/max queries. start is taken when busy is low; results are strobed on
// out_valid for one cycle and cannot be stalled. Load words and clears do not
// raise busy, but a repeat count holds busy for one write of the last sample per
// repeat, up to the free room. A point query answers after one memory read, a
// range after one memory read per sample. Out-of-bounds queries answer on the
// next cycle. No clearing pass after reset.
module delta_rle_decode_range_minmax #(
  parameter int unsigned STORE_DEPTH  = 1024,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  output logic                                       busy,
  input  drm_pkg::op_t                               in_op,
  input  logic signed [drm_pkg::WORD_W-1:0]          in_word,
  input  logic [drm_pkg::INDEX_W-1:0]                in_first_index,
  input  logic [drm_pkg::INDEX_W-1:0]                in_last_index,
  output logic                                       out_valid,
  output logic signed [drm_pkg::FIELD_W-1:0]         out_sample,
  output logic signed [drm_pkg::FIELD_W-1:0]         out_range_min,
  output logic signed [drm_pkg::FIELD_W-1:0]         out_range_max,
  output logic                                       out_query_error,
  output logic                                       out_overflowed
);
  import drm_pkg::*;

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned IX = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int unsigned XW = (CW > WORD_W) ? CW : WORD_W;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [SW-1:0] last_r, last_nxt;
  logic          await_r, await_nxt;
  logic          started_r, started_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic [INDEX_W-1:0] ptr_r, ptr_nxt;
  logic [INDEX_W-1:0] end_r, end_nxt;
  logic          iss_last_r, iss_last_nxt;
  logic          first_r, first_nxt;

  logic          ov_valid_r, ov_valid_nxt;
  logic signed [FIELD_W-1:0] ov_sample_r, ov_sample_nxt;
  logic signed [FIELD_W-1:0] ov_min_r, ov_min_nxt;
  logic signed [FIELD_W-1:0] ov_max_r, ov_max_nxt;
  logic          ov_err_r, ov_err_nxt;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [SW-1:0] wdata, rdata;
  mm_ctl_t       mm_ctl;
  logic signed [SW-1:0] lo_nxt, hi_nxt;

  logic [SW-1:0] word_ext;
  logic [IX-1:0] a_x, b_x, cnt_x;
  logic [XW-1:0] n_x, room_x, k_x;
  logic          full;

  assign word_ext = SW'(in_word);
  assign a_x      = IX'(in_first_index);
  assign b_x      = IX'(in_last_index);
  assign cnt_x    = IX'(count_r);
  assign full     = (count_r == CW'(STORE_DEPTH));
  assign n_x      = XW'(in_word[WORD_W-2:0]);
  assign room_x   = XW'(CW'(STORE_DEPTH) - count_r);
  assign k_x      = (n_x < room_x) ? n_x : room_x;

  drm_store #(.DEPTH(STORE_DEPTH), .DW(SW)) u_store (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (waddr),
    .wr_data (wdata),
    .rd_en   (re),
    .rd_addr (raddr),
    .rd_data (rdata)
  );

  drm_minmax #(.DW(SW)) u_minmax (
    .clk    (clk),
    .ctl    (mm_ctl),
    .data   (rdata),
    .lo_nxt (lo_nxt),
    .hi_nxt (hi_nxt)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    last_nxt      = last_r;
    await_nxt     = await_r;
    started_nxt   = started_r;
    ovf_nxt       = ovf_r;
    left_nxt      = left_r;
    ptr_nxt       = ptr_r;
    end_nxt       = end_r;
    iss_last_nxt  = iss_last_r;
    first_nxt     = first_r;
    ov_valid_nxt  = 1'b0;
    ov_sample_nxt = ov_sample_r;
    ov_min_nxt    = ov_min_r;
    ov_max_nxt    = ov_max_r;
    ov_err_nxt    = ov_err_r;
    we            = 1'b0;
    waddr         = count_r[AW-1:0];
    wdata         = last_r;
    re            = 1'b0;
    raddr         = a_x[AW-1:0];
    mm_ctl        = '{en: 1'b0, first: first_r};

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_op)
            OP_LOAD: begin
              if (!started_r || (!await_r && in_word != '0)) begin
                if (!started_r) begin
                  wdata       = word_ext;
                  started_nxt = 1'b1;
                end else begin
                  wdata = last_r + word_ext;
                end
                last_nxt = wdata;
                if (!full) begin
                  we        = 1'b1;
                  count_nxt = count_r + 1'b1;
                end else begin
                  ovf_nxt = 1'b1;
                end
              end else if (await_r) begin
                await_nxt = 1'b0;
                if (in_word > 0) begin
                  if (n_x > room_x) begin
                    ovf_nxt = 1'b1;
                  end
                  if (k_x != '0) begin
                    left_nxt  = CW'(k_x);
                    state_nxt = ST_RUN;
                  end
                end
              end else begin
                await_nxt = 1'b1;
              end
            end
            OP_POINT: begin
              if (a_x >= cnt_x) begin
                ov_valid_nxt  = 1'b1;
                ov_err_nxt    = 1'b1;
                ov_sample_nxt = '0;
                ov_min_nxt    = '0;
                ov_max_nxt    = '0;
              end else begin
                re        = 1'b1;
                state_nxt = ST_PREAD;
              end
            end
            OP_RANGE: begin
              if (a_x > b_x || b_x >= cnt_x) begin
                ov_valid_nxt  = 1'b1;
                ov_err_nxt    = 1'b1;
                ov_sample_nxt = '0;
                ov_min_nxt    = '0;
                ov_max_nxt    = '0;
              end else begin
                re           = 1'b1;
                ptr_nxt      = in_first_index + 1'b1;
                end_nxt      = in_last_index;
                iss_last_nxt = (in_first_index == in_last_index);
                first_nxt    = 1'b1;
                state_nxt    = ST_RSCAN;
              end
            end
            OP_CLEAR: begin
              count_nxt   = '0;
              last_nxt    = '0;
              await_nxt   = 1'b0;
              started_nxt = 1'b0;
              ovf_nxt     = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        we        = 1'b1;
        count_nxt = count_r + 1'b1;
        left_nxt  = left_r - 1'b1;
        if (left_r == CW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PREAD: begin
        ov_valid_nxt  = 1'b1;
        ov_err_nxt    = 1'b0;
        ov_sample_nxt = FIELD_W'(rdata);
        ov_min_nxt    = '0;
        ov_max_nxt    = '0;
        state_nxt     = ST_IDLE;
      end
      ST_RSCAN: begin
        mm_ctl.en = 1'b1;
        first_nxt = 1'b0;
        if (iss_last_r) begin
          ov_valid_nxt  = 1'b1;
          ov_err_nxt    = 1'b0;
          ov_sample_nxt = '0;
          ov_min_nxt    = FIELD_W'(lo_nxt);
          ov_max_nxt    = FIELD_W'(hi_nxt);
          state_nxt     = ST_IDLE;
        end else begin
          re           = 1'b1;
          raddr        = AW'(ptr_r);
          ptr_nxt      = ptr_r + 1'b1;
          iss_last_nxt = (ptr_r == end_r);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      last_r     <= '0;
      await_r    <= 1'b0;
      started_r  <= 1'b0;
      ovf_r      <= 1'b0;
      ov_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      last_r     <= last_nxt;
      await_r    <= await_nxt;
      started_r  <= started_nxt;
      ovf_r      <= ovf_nxt;
      ov_valid_r <= ov_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r      <= left_nxt;
    ptr_r       <= ptr_nxt;
    end_r       <= end_nxt;
    iss_last_r  <= iss_last_nxt;
    first_r     <= first_nxt;
    ov_sample_r <= ov_sample_nxt;
    ov_min_r    <= ov_min_nxt;
    ov_max_r    <= ov_max_nxt;
    ov_err_r    <= ov_err_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = ov_valid_r;
  assign out_sample      = ov_sample_r;
  assign out_range_min   = ov_min_r;
  assign out_range_max   = ov_max_r;
  assign out_query_error = ov_err_r;
  assign out_overflowed  = ovf_r;

endmodule

FILE: design/drm_checker.sv
module drm_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input drm_pkg::op_t                       in_op,
  input logic [drm_pkg::INDEX_W-1:0]        in_first_index,
  input logic [drm_pkg::INDEX_W-1:0]        in_last_index,
  input logic                               out_valid,
  input logic signed [drm_pkg::FIELD_W-1:0] out_sample,
  input logic signed [drm_pkg::FIELD_W-1:0] out_range_min,
  input logic signed [drm_pkg::FIELD_W-1:0] out_range_max,
  input logic                               out_query_error
);
  import drm_pkg::*;

  // load and clear transactions never produce a result
  a_no_result_after_load_clear: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_op == OP_LOAD || in_op == OP_CLEAR) |=> !out_valid)
    else $error("result after load or clear");

  // a clear leaves busy low
  a_clear_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_op == OP_CLEAR |=> !busy)
    else $error("busy after clear");

  // reversed range is rejected on the next cycle
  a_reversed_range_error: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_op == OP_RANGE && in_first_index > in_last_index
    |=> out_valid && out_query_error)
    else $error("reversed range not flagged");

  // an errored result carries zero payload
  a_error_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_query_error
    |-> out_sample == '0 && out_range_min == '0 && out_range_max == '0)
    else $error("nonzero payload on error");

  // a point result leaves min and max at zero
  a_point_excludes_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample != '0 |-> out_range_min == '0 && out_range_max == '0)
    else $error("mixed point and range payload");

endmodule

bind delta_rle_decode_range_minmax drm_checker u_drm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_op           (in_op),
  .in_first_index  (in_first_index),
  .in_last_index   (in_last_index),
  .out_valid       (out_valid),
  .out_sample      (out_sample),
  .out_range_min   (out_range_min),
  .out_range_max   (out_range_max),
  .out_query_error (out_query_error)
);
